// ===== rtl/core/usan_pkg.sv =====
`timescale 1ns / 1ps

package usan_pkg;

	// Byte classes of lax UTF-8
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;

	// Replacement character EF BF BD
	localparam logic [7:0] REPL_B0 = 8'hEF;
	localparam logic [7:0] REPL_B1 = 8'hBF;
	localparam logic [7:0] REPL_B2 = 8'hBD;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Units per command: up to three held bytes plus the new one
	localparam int CMD_UNITS = 4;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_last;
	} out_item_t;

	// One command: a list of units, each a raw byte or a replacement triple
	typedef struct packed {
		logic [CMD_UNITS-1:0][7:0] unit_byte;
		logic [CMD_UNITS-1:0]      unit_repl;
		logic [1:0]                unit_last;
		logic                      eos;
	} cmd_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// Sequence length announced by a byte; zero for a bad lead
	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b < CONT_LO) begin
			len = 3'd1;
		end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
			len = 3'd2;
		end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
			len = 3'd3;
		end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
			len = 3'd4;
		end
		return len;
	endfunction

endpackage

// ===== rtl/core/usan_front.sv =====
`timescale 1ns / 1ps

module usan_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  usan_pkg::in_item_t src_item,
	input  usan_pkg::q_status_t q_status,
	output logic               push,
	output usan_pkg::cmd_t     push_cmd
);

	logic [1:0] held_cnt_q;
	logic [2:0] exp_len_q;
	logic [7:0] held_q [3];

	logic       accept;
	logic [7:0] b;
	logic       eos;
	logic       is_cont;
	logic [2:0] len;
	logic [2:0] total;
	logic [1:0] held_cnt_d;
	logic [2:0] exp_len_d;
	logic       wr_en;
	logic [1:0] wr_idx;
	logic       emit;

	assign src_stall = q_status.full;
	assign accept    = src_valid && !q_status.full;
	assign b         = src_item.in_byte;
	assign eos       = src_item.end_of_string;
	assign is_cont   = (b >= usan_pkg::CONT_LO) && (b <= usan_pkg::CONT_HI);
	assign len       = usan_pkg::lead_len(b);
	assign total     = {1'b0, held_cnt_q} + 3'd1;
	assign push      = accept && emit;

	// Classify the byte against the open sequence and build a command
	always_comb begin
		push_cmd           = '0;
		push_cmd.unit_byte = {b, held_q[2], held_q[1], held_q[0]};
		push_cmd.eos       = eos;
		emit               = 1'b0;
		held_cnt_d         = held_cnt_q;
		exp_len_d          = exp_len_q;
		wr_en              = 1'b0;
		wr_idx             = held_cnt_q;
		if (held_cnt_q != 2'd0 && is_cont) begin
			if (total >= exp_len_q) begin
				push_cmd.unit_byte[held_cnt_q] = b;
				push_cmd.unit_last             = held_cnt_q;
				emit                           = 1'b1;
				held_cnt_d                     = 2'd0;
				exp_len_d                      = 3'd0;
			end else if (eos) begin
				push_cmd.unit_repl = '1;
				push_cmd.unit_last = held_cnt_q;
				emit               = 1'b1;
				held_cnt_d         = 2'd0;
				exp_len_d          = 3'd0;
			end else begin
				wr_en      = 1'b1;
				held_cnt_d = held_cnt_q + 2'd1;
			end
		end else begin
			// replace every held byte, then judge the new byte afresh
			for (int i = 0; i < usan_pkg::CMD_UNITS; i++) begin
				push_cmd.unit_repl[i] = (2'(i) < held_cnt_q);
			end
			held_cnt_d = 2'd0;
			exp_len_d  = 3'd0;
			if (len == 3'd1) begin
				push_cmd.unit_byte[held_cnt_q] = b;
				push_cmd.unit_last             = held_cnt_q;
				emit                           = 1'b1;
			end else if (len == 3'd0 || eos) begin
				push_cmd.unit_repl[held_cnt_q] = 1'b1;
				push_cmd.unit_last             = held_cnt_q;
				emit                           = 1'b1;
			end else begin
				if (held_cnt_q != 2'd0) begin
					push_cmd.unit_last = held_cnt_q - 2'd1;
					emit               = 1'b1;
				end
				wr_en      = 1'b1;
				wr_idx     = 2'd0;
				held_cnt_d = 2'd1;
				exp_len_d  = len;
			end
		end
	end

	// Advance the hold state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			exp_len_q  <= 3'd0;
		end else if (accept) begin
			held_cnt_q <= held_cnt_d;
			exp_len_q  <= exp_len_d;
		end
	end

	// Hold bytes of an open sequence
	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			held_q[wr_idx] <= b;
		end
	end

endmodule

// ===== rtl/core/usan_queue.sv =====
`timescale 1ns / 1ps

module usan_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  usan_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output usan_pkg::cmd_t      head,
	output usan_pkg::q_status_t q_status
);

	usan_pkg::cmd_t                 mem_q [usan_pkg::QUEUE_DEPTH];
	logic [usan_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [usan_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [usan_pkg::QUEUE_AW:0]    count_q;
	logic                           do_push;
	logic                           do_pop;

	assign q_status.full  = (count_q == (usan_pkg::QUEUE_AW+1)'(usan_pkg::QUEUE_DEPTH));
	assign q_status.empty = (count_q == '0);
	assign do_push        = push && !q_status.full;
	assign do_pop         = pop && !q_status.empty;
	assign head           = mem_q[rd_ptr_q];

	// Store commands
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/usan_back.sv =====
`timescale 1ns / 1ps

module usan_back (
	input  logic                clk,
	input  logic                arst_n,
	input  usan_pkg::cmd_t      head,
	input  usan_pkg::q_status_t q_status,
	output logic                pop,
	output logic                dst_valid,
	input  logic                dst_stall,
	output usan_pkg::out_item_t dst_item
);

	logic [1:0] unit_q;
	logic [1:0] sub_q;
	logic       cur_repl;
	logic       unit_end;
	logic       cmd_end;
	logic       take;
	logic [7:0] repl_byte;

	assign dst_valid = !q_status.empty;
	assign take      = dst_valid && !dst_stall;
	assign cur_repl  = head.unit_repl[unit_q];
	assign unit_end  = !cur_repl || (sub_q == 2'd2);
	assign cmd_end   = unit_end && (unit_q == head.unit_last);
	assign pop       = take && cmd_end;

	// Pick the replacement byte for the current step of the triple
	always_comb begin
		case (sub_q)
			2'd0:    repl_byte = usan_pkg::REPL_B0;
			2'd1:    repl_byte = usan_pkg::REPL_B1;
			default: repl_byte = usan_pkg::REPL_B2;
		endcase
	end

	assign dst_item.out_byte    = cur_repl ? repl_byte : head.unit_byte[unit_q];
	assign dst_item.run_last    = cmd_end;
	assign dst_item.string_last = cmd_end && head.eos;

	// Walk units and triple steps of the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q <= 2'd0;
			sub_q  <= 2'd0;
		end else if (take) begin
			if (cmd_end) begin
				unit_q <= 2'd0;
				sub_q  <= 2'd0;
			end else if (unit_end) begin
				unit_q <= unit_q + 2'd1;
				sub_q  <= 2'd0;
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/core/utf8_sanitizer_stream.sv =====
`timescale 1ns / 1ps

// UTF-8 sanitizer: bytes enter on the src channel and leave on the dst channel,
// with complete sequences passed through and every unusable byte turned into
// EF BF BD. Plain text moves one byte per cycle while dst_stall is low and the
// queue has room. Bytes of a multi-byte sequence are held in the front and
// produce nothing until the sequence completes; the whole sequence then leaves
// as one run. The back emits one output byte per cycle while dst_stall is low;
// one input byte can cause up to 12 output bytes, when a held sequence of three
// bytes is broken at end of string by a byte that cannot stand alone. A
// four-entry command queue between the front classifier and the back expander
// absorbs these bursts; src_stall rises only when that queue is full. Results
// appear, at the earliest, in the cycle after the causing byte is accepted.
module utf8_sanitizer_stream (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_stall,
	input  usan_pkg::in_item_t  src_item,
	output logic                dst_valid,
	input  logic                dst_stall,
	output usan_pkg::out_item_t dst_item
);

	usan_pkg::q_status_t q_status;
	usan_pkg::cmd_t      push_cmd;
	usan_pkg::cmd_t      head;
	logic                push;
	logic                pop;

	usan_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_item (src_item),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	usan_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.pop     (pop),
		.head    (head),
		.q_status(q_status)
	);

	usan_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_item (dst_item)
	);

endmodule

// ===== rtl/core/usan_checker.sv =====
`timescale 1ns / 1ps

module usan_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                src_valid,
	input logic                src_stall,
	input usan_pkg::in_item_t  src_item,
	input logic                dst_valid,
	input logic                dst_stall,
	input usan_pkg::out_item_t dst_item
);

	// Hold a stalled input item
	a_src_hold: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_stall |=> src_valid && $stable(src_item))
		else $error("stalled input item changed");

	// Hold a stalled result
	a_dst_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
		else $error("stalled result changed");

	// Flag the end of a string only on the last byte of a run
	a_last_order: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.string_last |-> dst_item.run_last)
		else $error("string_last without run_last");

	// Drop bytes that can never be valid UTF-8
	a_no_bad_byte: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid |-> !(dst_item.out_byte == 8'hC0 || dst_item.out_byte == 8'hC1 ||
			dst_item.out_byte >= 8'hF5))
		else $error("invalid byte emitted");

	// End no run on a lead byte
	a_no_trailing_lead: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_item.run_last |->
			!(dst_item.out_byte >= usan_pkg::LEAD2_LO &&
				dst_item.out_byte <= usan_pkg::LEAD4_HI))
		else $error("run ends on a lead byte");

endmodule

bind utf8_sanitizer_stream usan_checker u_usan_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.src_valid(src_valid),
	.src_stall(src_stall),
	.src_item (src_item),
	.dst_valid(dst_valid),
	.dst_stall(dst_stall),
	.dst_item (dst_item)
);

// ===== dv/tb_utf8_sanitizer_stream.sv =====
`timescale 1ns / 1ps

module tb_utf8_sanitizer_stream;

	localparam int DIR_ROWS    = 24;
	localparam int PHASE_ITEMS = 80;
	localparam int HOLD_CYCLES = 80;
	localparam int TAIL_CYCLES = 30;

	typedef enum logic [1:0] {
		ROW_PREDICT,
		ROW_PASS,
		ROW_REPLACE
	} row_kind_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       eos;
		row_kind_t  kind;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                src_valid;
	logic                src_stall;
	usan_pkg::in_item_t  src_item;
	logic                dst_valid;
	logic                dst_stall;
	usan_pkg::out_item_t dst_item;

	// Shadow of the sequence held inside the block
	logic [7:0] seq_bytes [3];
	logic [1:0] seq_cnt;
	logic [2:0] seq_len;

	logic [7:0]          byte_run [$];
	usan_pkg::out_item_t pending_out_q [$];
	usan_pkg::in_item_t  stim_q [$];
	logic [7:0]          raw_q [$];
	dir_row_t            dir_rows [DIR_ROWS];

	int src_idle_pct;
	int dst_stall_pct;
	int hold_left;
	bit hold_req;
	int items_sent;
	int outs_checked;
	int stall_cycles;
	int errors;

	utf8_sanitizer_stream uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_item  (src_item),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_item  (dst_item)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 300000);
		$display("tb_utf8_sanitizer_stream: FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	// Sequence length a byte announces; zero for a byte that cannot lead
	function automatic int seq_length(input logic [7:0] b);
		if (b < usan_pkg::CONT_LO) return 1;
		if (b >= usan_pkg::LEAD2_LO && b <= usan_pkg::LEAD2_HI) return 2;
		if (b >= usan_pkg::LEAD3_LO && b <= usan_pkg::LEAD3_HI) return 3;
		if (b >= usan_pkg::LEAD4_LO && b <= usan_pkg::LEAD4_HI) return 4;
		return 0;
	endfunction

	task automatic add_replacement();
		byte_run.push_back(usan_pkg::REPL_B0);
		byte_run.push_back(usan_pkg::REPL_B1);
		byte_run.push_back(usan_pkg::REPL_B2);
	endtask

	// Work out the output bytes of one item and advance the shadow state
	task automatic sanitize_byte(input usan_pkg::in_item_t it);
		int i;
		int len;
		byte_run.delete();
		if (seq_cnt != 0 && it.in_byte >= usan_pkg::CONT_LO &&
			it.in_byte <= usan_pkg::CONT_HI) begin
			if (seq_cnt + 1 >= seq_len) begin
				for (i = 0; i < seq_cnt; i++) byte_run.push_back(seq_bytes[i]);
				byte_run.push_back(it.in_byte);
				seq_cnt = 0;
			end else if (it.end_of_string) begin
				for (i = 0; i <= seq_cnt; i++) add_replacement();
				seq_cnt = 0;
			end else begin
				seq_bytes[seq_cnt] = it.in_byte;
				seq_cnt++;
			end
		end else begin
			// Flush a broken sequence, then judge the byte afresh
			for (i = 0; i < seq_cnt; i++) add_replacement();
			seq_cnt = 0;
			len = seq_length(it.in_byte);
			if (len == 1) begin
				byte_run.push_back(it.in_byte);
			end else if (len == 0 || it.end_of_string) begin
				add_replacement();
			end else begin
				seq_bytes[0] = it.in_byte;
				seq_cnt = 1;
				seq_len = len[2:0];
			end
		end
		if (it.end_of_string) seq_cnt = 0;
	endtask

	// Turn the byte run into expected output items with their flags
	task automatic queue_results(input logic eos);
		int i;
		usan_pkg::out_item_t e;
		for (i = 0; i < byte_run.size(); i++) begin
			e.out_byte    = byte_run[i];
			e.run_last    = (i == byte_run.size() - 1);
			e.string_last = e.run_last && eos;
			pending_out_q.push_back(e);
		end
	endtask

	// Offer one item, with random idle gaps, and hold it until taken
	task automatic offer_item(input usan_pkg::in_item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_item  <= it;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		items_sent++;
	endtask

	// Build one random string: mostly well-formed characters, some noise
	task automatic gen_string();
		int nchars;
		int k;
		int j;
		int kind;
		int len;
		int r;
		usan_pkg::in_item_t it;
		raw_q.delete();
		nchars = $urandom_range(1, 10);
		for (k = 0; k < nchars; k++) begin
			kind = $urandom_range(99);
			len  = $urandom_range(1, 4);
			if (kind < 80 && !(kind >= 70 && len == 1)) begin
				case (len)
					1: raw_q.push_back(8'($urandom_range(8'h00, 8'h7F)));
					2: raw_q.push_back(8'($urandom_range(usan_pkg::LEAD2_LO,
						usan_pkg::LEAD2_HI)));
					3: raw_q.push_back(8'($urandom_range(usan_pkg::LEAD3_LO,
						usan_pkg::LEAD3_HI)));
					default: raw_q.push_back(8'($urandom_range(usan_pkg::LEAD4_LO,
						usan_pkg::LEAD4_HI)));
				endcase
				// Truncate the sequence when in the broken band
				if (kind >= 70) len = $urandom_range(1, len - 1);
				for (j = 1; j < len; j++)
					raw_q.push_back(8'($urandom_range(usan_pkg::CONT_LO, usan_pkg::CONT_HI)));
			end else if (kind < 88) begin
				raw_q.push_back(8'($urandom_range(usan_pkg::CONT_LO, usan_pkg::CONT_HI)));
			end else if (kind < 94) begin
				r = $urandom_range(0, 12);
				raw_q.push_back(8'((r < 2) ? 8'hC0 + r : 8'hF3 + r));
			end else begin
				raw_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		for (j = 0; j < raw_q.size(); j++) begin
			it.in_byte       = raw_q[j];
			it.end_of_string = (j == raw_q.size() - 1);
			stim_q.push_back(it);
		end
	endtask

	task automatic run_strings(input int n_items);
		stim_q.delete();
		while (stim_q.size() < n_items) gen_string();
		foreach (stim_q[i]) begin
			offer_item(stim_q[i]);
			sanitize_byte(stim_q[i]);
			queue_results(stim_q[i].end_of_string);
		end
		src_valid <= 1'b0;
		while (pending_out_q.size() != 0) @(posedge clk);
	endtask

	// Output stall: random, or a long hold counted in cycles on request
	initial begin
		dst_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				dst_stall <= 1'b1;
				hold_left--;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(99) < dst_stall_pct);
			end
		end
	end

	// Output side: check each item taken
	initial begin
		usan_pkg::out_item_t e;
		forever begin
			@(posedge clk);
			if (src_valid && src_stall) stall_cycles++;
			if (arst_n && dst_valid && !dst_stall) begin
				if (pending_out_q.size() == 0) begin
					report_mismatch($sformatf("unexpected output byte %02h", dst_item.out_byte));
				end else begin
					e = pending_out_q.pop_front();
					if (dst_item.out_byte !== e.out_byte)
						report_mismatch($sformatf("out_byte %02h, want %02h (output %0d)",
							dst_item.out_byte, e.out_byte, outs_checked));
					if (dst_item.run_last !== e.run_last)
						report_mismatch($sformatf("run_last %b, want %b (output %0d)",
							dst_item.run_last, e.run_last, outs_checked));
					if (dst_item.string_last !== e.string_last)
						report_mismatch($sformatf("string_last %b, want %b (output %0d)",
							dst_item.string_last, e.string_last, outs_checked));
				end
				outs_checked++;
			end
		end
	end

	// Stimulus: reset, directed table, idling phases, long output hold
	initial begin
		int r;
		int ph;
		dir_row_t row;
		usan_pkg::in_item_t it;
		int idle_pcts [4];
		int stall_pcts [4];

		arst_n        <= 1'b0;
		src_valid     <= 1'b0;
		src_item      <= '0;
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		hold_left     = 0;
		hold_req      = 1'b0;
		items_sent    = 0;
		outs_checked  = 0;
		stall_cycles  = 0;
		errors        = 0;
		seq_cnt       = 0;
		seq_len       = 0;
		idle_pcts     = '{0, 51, 0, 37};
		stall_pcts    = '{0, 0, 51, 37};

		dir_rows = '{
			{8'h00, 1'b0, ROW_PASS},     // lowest byte after reset
			{8'h80, 1'b0, ROW_REPLACE},  // stray continuation
			{8'hC1, 1'b0, ROW_REPLACE},  // bad lead
			{8'hF5, 1'b0, ROW_REPLACE},  // bad lead above four-byte range
			{8'hFF, 1'b1, ROW_REPLACE},  // highest byte, ends string
			{8'hC2, 1'b0, ROW_PREDICT},  // two-byte sequence
			{8'h80, 1'b0, ROW_PREDICT},
			{8'hF4, 1'b0, ROW_PREDICT},  // four-byte sequence
			{8'h8F, 1'b0, ROW_PREDICT},
			{8'hBF, 1'b0, ROW_PREDICT},
			{8'hBF, 1'b0, ROW_PREDICT},
			{8'hE2, 1'b0, ROW_PREDICT},  // sequence broken by plain text
			{8'h41, 1'b0, ROW_PREDICT},
			{8'hF0, 1'b0, ROW_PREDICT},  // three held, broken by lead at end
			{8'h90, 1'b0, ROW_PREDICT},
			{8'h80, 1'b0, ROW_PREDICT},
			{8'hF1, 1'b1, ROW_PREDICT},
			{8'hEF, 1'b0, ROW_PREDICT},  // three-byte sequence ending string
			{8'hBF, 1'b0, ROW_PREDICT},
			{8'hBF, 1'b1, ROW_PREDICT},
			{8'hE2, 1'b0, ROW_PREDICT},  // end of string inside sequence
			{8'h82, 1'b1, ROW_PREDICT},
			{8'hDF, 1'b1, ROW_REPLACE},  // lead as final byte
			{8'h7F, 1'b1, ROW_PASS}      // top plain byte ends string
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table; typed rows still advance the shadow state
		for (r = 0; r < DIR_ROWS; r++) begin
			row = dir_rows[r];
			it.in_byte       = row.in_byte;
			it.end_of_string = row.eos;
			offer_item(it);
			sanitize_byte(it);
			if (row.kind != ROW_PREDICT) begin
				byte_run.delete();
				if (row.kind == ROW_PASS) byte_run.push_back(row.in_byte);
				else add_replacement();
			end
			queue_results(row.eos);
		end
		src_valid <= 1'b0;
		while (pending_out_q.size() != 0) @(posedge clk);

		// Random strings under each idling mix
		for (ph = 0; ph < 4; ph++) begin
			src_idle_pct  = idle_pcts[ph];
			dst_stall_pct = stall_pcts[ph];
			run_strings(PHASE_ITEMS);
		end

		// Hold the output off while the input keeps offering items
		src_idle_pct  = 0;
		dst_stall_pct = 0;
		hold_req      = 1'b1;
		run_strings(40);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_out_q.size() != 0)
			report_mismatch($sformatf("%0d output bytes never arrived", pending_out_q.size()));

		$display("Covered %0d input items (directed, four idling mixes, long output hold),",
			items_sent);
		$display("checked %0d output bytes; input stalled %0d cycles; %0d mismatches.",
			outs_checked, stall_cycles, errors);
		if (errors == 0) begin
			$display("tb_utf8_sanitizer_stream: PASS");
		end else begin
			$display("tb_utf8_sanitizer_stream: FAIL");
		end
		$finish;
	end

endmodule
